/* hdl/assert_macros.svh */
// Assertion helpers shared by the RTL.
// Define NO_ASSERTIONS to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// The expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("%m: invariant violated");

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: sequence violated");

`else

`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* hdl/lps_pkg.sv */
package lps_pkg;

   localparam int CSR_W     = 7;
   localparam int CSR_IDX_W = 1;
   localparam int PIXEL_W   = 8;
   localparam int MUL_BIT_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SAMPLE_STEP   = 1'b0,
      CSR_COLUMN_HEIGHT = 1'b1
   } csr_index_type;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_TRACE = 1'b1;

   localparam logic [CSR_W-1:0]     SAMPLE_STEP_RESET   = 7'd1;
   localparam logic [CSR_W-1:0]     COLUMN_HEIGHT_RESET = 7'd64;
   localparam logic [MUL_BIT_W-1:0] MUL_LAST            = 3'd6;

endpackage

/* hdl/lps_ram.sv */
module lps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Single write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/line_profile_sampler.sv */
// line_profile_sampler: samples a column-major 8-bit image along a straight line.
//
// The request channel (req_valid / req_stall) carries two kinds of transfer. A write
// stores one pixel at req_write_address and yields no result; when the block is idle,
// writes may follow one another in every cycle. A trace walks from the start point to
// the end point one step at a time along the major axis, skipping the start point,
// and reads every sample_step-th point beginning with the first one. Each read comes
// out as one transfer on the result channel (rsp_valid / rsp_stall), and the final
// sample of a line carries rsp_last. A line of zero length yields nothing.
// A trace is accepted, forms its start address (a shift-and-add over the bits of
// column_height in the shared address adder), then takes a major step and a minor step
// per point, and for each sample a registered store read and the result transfer.
// req_stall is high for the whole trace. A stalled result simply holds the walk.
// The csr_ port must be written only while the block is idle; the block itself does not enforce this.
// Reset is synchronous and returns the sequencer to idle with sample_step at 1 and
// column_height at 64; the image store keeps whatever it held and must be written
// before it is read.
`include "assert_macros.svh"

module line_profile_sampler
   import lps_pkg::*;
#(
   parameter int SIDE        = 64,
   parameter int STORE_DEPTH = 4096
) (
   input  logic                           clock,
   input  logic                           reset,
   // Request channel.
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_operation,
   input  logic [$clog2(SIDE)-1:0]        req_start_x,
   input  logic [$clog2(SIDE)-1:0]        req_start_y,
   input  logic [$clog2(SIDE)-1:0]        req_end_x,
   input  logic [$clog2(SIDE)-1:0]        req_end_y,
   input  logic [$clog2(STORE_DEPTH)-1:0] req_write_address,
   input  logic [PIXEL_W-1:0]             req_write_value,
   // Result channel.
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [PIXEL_W-1:0]             rsp_pixel_value,
   output logic                           rsp_last,
   // Configuration write port.
   input  logic                           csr_write_enable,
   input  logic [CSR_IDX_W-1:0]           csr_index,
   input  logic [CSR_W-1:0]               csr_write_data
);

   // Coordinate width, signed delta width and width of the running error term.
   localparam int CW = $clog2(SIDE);
   localparam int DW = CW + 1;
   localparam int EW = CW + 4;
   // Store address width, and the width of the running line address, which must hold
   // any x * column_height + y as well as the store depth itself.
   localparam int AW = $clog2(STORE_DEPTH);
   localparam int LW = CW + CSR_W;
   localparam int PW = (LW > AW + 1) ? LW : AW + 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MULT,
      ST_MAJOR,
      ST_MINOR,
      ST_LOAD,
      ST_HOLD
   } state_type;

   state_type            state_ff;
   logic [CSR_W-1:0]     sample_step_ff;
   logic [CSR_W-1:0]     column_height_ff;

   // Walk state.
   logic [PW-1:0]        addr_ff;
   logic [PW-1:0]        maj_step_ff;
   logic [PW-1:0]        min_step_ff;
   logic signed [EW-1:0] err_ff;
   logic signed [EW-1:0] inc_a_ff;
   logic signed [EW-1:0] inc_b_ff;
   logic [CW-1:0]        n_ff;
   logic [CW-1:0]        rem_ff;
   logic [CSR_W-1:0]     cnt_ff;
   logic [CW-1:0]        sx_ff;
   logic [MUL_BIT_W-1:0] mul_bit_ff;
   logic                 oob_ff;

   // Result register.
   logic                 rsp_valid_ff;
   logic [PIXEL_W-1:0]   rsp_pixel_value_ff;
   logic                 rsp_last_ff;

   // Handshake decode.
   logic req_accept;
   logic trace_accept;
   logic write_accept;

   assign req_stall    = (state_ff != ST_IDLE);
   assign req_accept   = req_valid && !req_stall;
   assign trace_accept = req_accept && (req_operation == OP_TRACE);
   assign write_accept = req_accept && (req_operation == OP_WRITE) &&
                         ({1'b0, req_write_address} < (AW + 1)'(STORE_DEPTH));

   // Line set-up, decoded straight from the request fields when a trace arrives.
   logic signed [DW-1:0] dx_s;
   logic signed [DW-1:0] dy_s;
   logic signed [DW-1:0] ax_s;
   logic signed [DW-1:0] ay_s;
   logic                 pos_x;
   logic                 pos_y;
   logic                 x_major;
   logic [CW-1:0]        n_in;
   logic signed [DW-1:0] inc_a_half;
   logic signed [DW-1:0] inc_b_half;
   logic [PW-1:0]        h_ext;
   logic [PW-1:0]        x_step;
   logic [PW-1:0]        y_step;
   logic                 zero_line;

   assign dx_s  = $signed({1'b0, req_end_x}) - $signed({1'b0, req_start_x});
   assign dy_s  = $signed({1'b0, req_end_y}) - $signed({1'b0, req_start_y});
   assign ax_s  = dx_s[DW-1] ? -dx_s : dx_s;
   assign ay_s  = dy_s[DW-1] ? -dy_s : dy_s;
   assign pos_x = !dx_s[DW-1] && (dx_s != '0);
   assign pos_y = !dy_s[DW-1] && (dy_s != '0);
   // Ties go to the y axis.
   assign x_major   = (ay_s < ax_s);
   assign n_in      = x_major ? ax_s[CW-1:0] : ay_s[CW-1:0];
   assign zero_line = (dx_s == '0) && (dy_s == '0);

   // The error term is 2*M*dMinor - 2*m*dMajor over the major and minor offsets M and
   // m. A major step adds 2*sign(dMajor)*dMinor and a minor step takes away
   // 2*sign(dMinor)*dMajor, where a zero delta counts as negative.
   always_comb begin
      if (x_major) begin
         inc_a_half = pos_x ? dy_s : -dy_s;
         inc_b_half = pos_y ? dx_s : -dx_s;
      end else begin
         inc_a_half = pos_y ? dx_s : -dx_s;
         inc_b_half = pos_x ? dy_s : -dy_s;
      end
   end

   // A column move shifts the address by the column height, a row move by one.
   assign h_ext  = PW'(column_height_ff);
   assign x_step = pos_x ? h_ext : -h_ext;
   assign y_step = pos_y ? PW'(1) : {PW{1'b1}};

   // Shared address adder: forms the start address by shift-and-add, then applies the
   // major and minor steps of the walk.
   logic [PW-1:0] alu_b;
   logic [PW-1:0] addr_in;

   always_comb begin
      case (state_ff)
         ST_MULT: begin
            alu_b = column_height_ff[mul_bit_ff] ? (PW'(sx_ff) << mul_bit_ff) : '0;
         end
         ST_MAJOR: begin
            alu_b = maj_step_ff;
         end
         default: begin
            alu_b = min_step_ff;
         end
      endcase
   end

   assign addr_in = addr_ff + alu_b;

   // Minor step decision on the error after the major step.
   logic signed [EW-1:0] err_in;
   logic [EW-1:0]        err_abs;
   logic                 minor_move;
   logic [PW-1:0]        point_addr;
   logic                 emit;
   logic                 last_in;

   assign err_in     = err_ff + inc_a_ff;
   assign err_abs    = err_ff[EW-1] ? -err_ff : err_ff;
   assign minor_move = (err_abs > EW'(n_ff));
   assign point_addr = minor_move ? addr_in : addr_ff;
   assign emit       = (cnt_ff == '0);
   // rem_ff counts the points that follow the current one.
   assign last_in    = (sample_step_ff == '0) || (CSR_W'(rem_ff) < sample_step_ff);

   logic [PIXEL_W-1:0] rd_data;

   lps_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (STORE_DEPTH)
   ) u_image_store (
      .clock   (clock),
      .wr_en   (write_accept),
      .wr_addr (req_write_address),
      .wr_data (req_write_value),
      .rd_en   ((state_ff == ST_MINOR) && emit),
      .rd_addr (point_addr[AW-1:0]),
      .rd_data (rd_data)
   );

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         sample_step_ff   <= SAMPLE_STEP_RESET;
         column_height_ff <= COLUMN_HEIGHT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_SAMPLE_STEP:   sample_step_ff   <= csr_write_data;
            CSR_COLUMN_HEIGHT: column_height_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Sequencer with its walk registers and the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (trace_accept && !zero_line) begin
                  sx_ff       <= req_start_x;
                  addr_ff     <= PW'(req_start_y);
                  mul_bit_ff  <= '0;
                  err_ff      <= '0;
                  inc_a_ff    <= {{(EW-DW-1){inc_a_half[DW-1]}}, inc_a_half, 1'b0};
                  inc_b_ff    <= {{(EW-DW-1){inc_b_half[DW-1]}}, inc_b_half, 1'b0};
                  maj_step_ff <= x_major ? x_step : y_step;
                  min_step_ff <= x_major ? y_step : x_step;
                  n_ff        <= n_in;
                  rem_ff      <= n_in;
                  cnt_ff      <= '0;
                  state_ff    <= ST_MULT;
               end
            end
            ST_MULT: begin
               addr_ff    <= addr_in;
               mul_bit_ff <= mul_bit_ff + 1'b1;
               if (mul_bit_ff == MUL_LAST) begin
                  state_ff <= ST_MAJOR;
               end
            end
            ST_MAJOR: begin
               addr_ff  <= addr_in;
               err_ff   <= err_in;
               rem_ff   <= rem_ff - 1'b1;
               state_ff <= ST_MINOR;
            end
            ST_MINOR: begin
               addr_ff <= point_addr;
               if (minor_move) begin
                  err_ff <= err_ff - inc_b_ff;
               end
               cnt_ff <= emit ? (sample_step_ff - 1'b1) : (cnt_ff - 1'b1);
               if (emit) begin
                  oob_ff      <= (point_addr >= PW'(STORE_DEPTH));
                  rsp_last_ff <= last_in;
                  state_ff    <= ST_LOAD;
               end else if (rem_ff == '0) begin
                  state_ff <= ST_IDLE;
               end else begin
                  state_ff <= ST_MAJOR;
               end
            end
            ST_LOAD: begin
               // Points beyond the store read as zero.
               rsp_pixel_value_ff <= oob_ff ? '0 : rd_data;
               rsp_valid_ff       <= 1'b1;
               state_ff           <= ST_HOLD;
            end
            ST_HOLD: begin
               if (!rsp_stall) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= (rem_ff == '0) ? ST_IDLE : ST_MAJOR;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_value = rsp_pixel_value_ff;
   assign rsp_last        = rsp_last_ff;

   // A result is only ever presented from the hold state.
   `ASSERT_ALWAYS(a_valid_in_hold, clock, reset, !rsp_valid_ff || (state_ff == ST_HOLD))
   // New requests are never taken while a result is still pending.
   `ASSERT_ALWAYS(a_no_accept_with_result, clock, reset, !req_accept || !rsp_valid_ff)
   // A major step is only taken while points of the line remain.
   `ASSERT_ALWAYS(a_major_has_points, clock, reset, (state_ff != ST_MAJOR) || (rem_ff != '0))
   // The read data captured in the load state is presented in the next cycle.
   `ASSERT_NEXT(a_load_presents, clock, reset, state_ff == ST_LOAD, rsp_valid_ff)

endmodule

/* verif/testbench.sv */
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import lps_pkg::*;

   localparam int STORE_DEPTH = 4096;

   // One request as it waits to be driven. The hold flag asks the driver to wait until
   // every sample that is already expected has arrived before it offers this request.
   typedef struct {
      logic       operation;
      logic [5:0] start_x;
      logic [5:0] start_y;
      logic [5:0] end_x;
      logic [5:0] end_y;
      logic [11:0] write_address;
      logic [7:0] write_value;
      bit         hold_until_drained;
   } lps_request_type;

   // One sample as it should come out of the result channel.
   typedef struct {
      logic [7:0] pixel_value;
      logic       last;
   } sample_type;

   typedef int unsigned addr_list_type[$];

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              req_valid = 1'b0;
   logic              req_stall;
   logic              req_operation = OP_WRITE;
   logic [5:0]        req_start_x = '0;
   logic [5:0]        req_start_y = '0;
   logic [5:0]        req_end_x = '0;
   logic [5:0]        req_end_y = '0;
   logic [11:0]       req_write_address = '0;
   logic [7:0]        req_write_value = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [PIXEL_W-1:0] rsp_pixel_value;
   logic              rsp_last;
   logic              csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_SAMPLE_STEP;
   logic [CSR_W-1:0]  csr_write_data = '0;

   line_profile_sampler u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_start_x       (req_start_x),
      .req_start_y       (req_start_y),
      .req_end_x         (req_end_x),
      .req_end_y         (req_end_y),
      .req_write_address (req_write_address),
      .req_write_value   (req_write_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_pixel_value   (rsp_pixel_value),
      .rsp_last          (rsp_last),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   // Requests waiting to be driven, filled by the stimulus process.
   lps_request_type pending_requests[$];
   // Samples predicted for accepted traces, oldest first.
   sample_type      expected_samples[$];
   // The request currently offered on the request channel.
   lps_request_type on_bus;

   // Our own copy of the image store and of the two registers. The store copy is updated
   // when a write transfer is accepted; pixel_known is updated when a write is queued, so
   // that the stimulus never queues a trace that would read a pixel nobody has written.
   logic [7:0]  pixel_store [STORE_DEPTH];
   bit          pixel_known [STORE_DEPTH];
   int unsigned step_setting = 1;
   int unsigned height_setting = 64;

   bit req_taken = 1'b0;
   int send_gap = 0;
   int stall_left = 0;
   bit send_calm = 1'b0;
   bit sink_calm = 1'b0;

   int queued_count = 0;
   int accepted_count = 0;
   int traces_done = 0;
   int writes_done = 0;
   int empty_lines = 0;
   int samples_outside = 0;
   int samples_checked = 0;
   int settings_applied = 0;
   int error_count = 0;

   // Register settings of the random phases; a last phase picks both at random.
   int unsigned plan_step[8]   = '{1, 2, 5, 64, 0, 1, 127, 3};
   int unsigned plan_height[8] = '{64, 64, 23, 1, 37, 0, 127, 50};

   initial begin
      forever #4 clock = ~clock;
   end

   // Walks the line from the start point towards the end point and returns the store
   // address of every point that is sampled, in order. The major axis is x only when the
   // horizontal distance is strictly larger; ties go to y. After each major step the minor
   // coordinate moves once the exact offset |2*i*dMinor - 2*j*dMajor| exceeds |dMajor|.
   // The start point is skipped. A step setting of zero keeps only the first point.
   function automatic addr_list_type walk_line(input int sx, input int sy, input int ex,
                                               input int ey, input int unsigned every,
                                               input int unsigned rows);
      addr_list_type addrs;
      int dx, dy, ax, ay, gx, gy, x, y, n, off;
      int unsigned point;
      bit x_major;
      bit emit;
      dx = ex - sx;
      dy = ey - sy;
      if (dx == 0 && dy == 0) begin
         return addrs;
      end
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      gx = (dx > 0) ? 1 : -1;
      gy = (dy > 0) ? 1 : -1;
      x_major = (ay < ax);
      n = x_major ? ax : ay;
      x = 0;
      y = 0;
      for (int i = 0; i < n; i++) begin
         if (x_major) begin
            x += gx;
         end else begin
            y += gy;
         end
         off = 2 * x * dy - 2 * y * dx;
         if (off < 0) begin
            off = -off;
         end
         if (x_major && off > ax) begin
            y += gy;
         end else if (!x_major && off > ay) begin
            x += gx;
         end
         emit = (every == 0) ? (i == 0) : ((i % every) == 0);
         if (emit) begin
            point = int'(sx + x) * rows + int'(sy + y);
            addrs.insert(addrs.size(), point);
         end
      end
      return addrs;
   endfunction

   // Idle lengths: mostly none or short, now and then long. While a side is calm it does
   // not idle at all, which gives stretches of back-to-back transfers.
   function automatic int pick_gap(input bit calm);
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) begin
         return 0;
      end
      if (r < 88) begin
         return $urandom_range(1, 3);
      end
      if (r < 97) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(16, 40);
   endfunction

   function automatic int clip_coord(input int v);
      return (v < 0) ? 0 : ((v > 63) ? 63 : v);
   endfunction

   // A write carries random coordinates, which the block must ignore.
   task automatic queue_write(input int unsigned addr, input int unsigned value);
      lps_request_type item;
      item.operation = OP_WRITE;
      item.start_x = 6'($urandom);
      item.start_y = 6'($urandom);
      item.end_x = 6'($urandom);
      item.end_y = 6'($urandom);
      item.write_address = addr[11:0];
      item.write_value = value[7:0];
      item.hold_until_drained = 1'b0;
      pixel_known[addr[11:0]] = 1'b1;
      pending_requests.insert(pending_requests.size(), item);
      queued_count++;
   endtask

   // A trace is preceded by writes of every pixel inside the store that it is going to
   // read and that has not been written yet, so that each read is of a defined pixel.
   // The write fields of a trace are random, and the block must ignore them.
   task automatic queue_trace(input int sx, input int sy, input int ex, input int ey,
                              input bit hold);
      addr_list_type addrs;
      lps_request_type item;
      addrs = walk_line(sx, sy, ex, ey, step_setting, height_setting);
      foreach (addrs[k]) begin
         if (addrs[k] < STORE_DEPTH && !pixel_known[addrs[k][11:0]]) begin
            queue_write(addrs[k], $urandom_range(0, 255));
         end
      end
      item.operation = OP_TRACE;
      item.start_x = sx[5:0];
      item.start_y = sy[5:0];
      item.end_x = ex[5:0];
      item.end_y = ey[5:0];
      item.write_address = 12'($urandom);
      item.write_value = 8'($urandom);
      item.hold_until_drained = hold;
      pending_requests.insert(pending_requests.size(), item);
      queued_count++;
   endtask

   // Mostly short lines, some of medium length, a few spanning the image and a few of
   // zero length.
   task automatic queue_random_line(input bit hold);
      int sx, sy, ex, ey, reach, r;
      r = $urandom_range(0, 99);
      sx = $urandom_range(0, 63);
      sy = $urandom_range(0, 63);
      if (r < 5) begin
         ex = sx;
         ey = sy;
      end else if (r < 12) begin
         ex = $urandom_range(0, 63);
         ey = $urandom_range(0, 63);
      end else begin
         reach = (r < 30) ? 24 : 8;
         ex = clip_coord(sx + int'($urandom_range(0, 2 * reach)) - reach);
         ey = clip_coord(sy + int'($urandom_range(0, 2 * reach)) - reach);
      end
      queue_trace(sx, sy, ex, ey, hold);
   endtask

   // Both registers are written in successive cycles while the block is idle.
   task automatic apply_settings(input int unsigned every, input int unsigned rows);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_SAMPLE_STEP;
      csr_write_data <= every[6:0];
      @(negedge clock);
      csr_index <= CSR_COLUMN_HEIGHT;
      csr_write_data <= rows[6:0];
      @(negedge clock);
      csr_write_enable <= 1'b0;
      step_setting = every & 32'h7F;
      height_setting = rows & 32'h7F;
      settings_applied++;
   endtask

   // Waits until every queued request has been accepted and every expected sample has
   // come back, then lets the block finish a walk that may continue past its last sample.
   task automatic wait_for_idle();
      while (accepted_count != queued_count || expected_samples.size() != 0) begin
         @(posedge clock);
      end
      repeat (300) @(posedge clock);
   endtask

   // Request driver. A payload is held until its transfer; after each transfer a random
   // idle gap may follow. A request marked to hold waits until nothing is expected.
   always @(negedge clock) begin : request_driver
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         // Still stalled: the payload stays as it is.
      end else if (send_gap > 0) begin
         send_gap--;
         req_valid <= 1'b0;
      end else if (pending_requests.size() != 0 &&
                   !(pending_requests[0].hold_until_drained &&
                     expected_samples.size() != 0)) begin
         on_bus = pending_requests.pop_front();
         req_valid <= 1'b1;
         req_operation <= on_bus.operation;
         req_start_x <= on_bus.start_x;
         req_start_y <= on_bus.start_y;
         req_end_x <= on_bus.end_x;
         req_end_y <= on_bus.end_y;
         req_write_address <= on_bus.write_address;
         req_write_value <= on_bus.write_value;
         if ($urandom_range(0, 39) == 0) begin
            send_calm = !send_calm;
         end
         send_gap = pick_gap(send_calm);
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Result sink: stall bursts of random length, with open cycles between the bursts.
   always @(negedge clock) begin : result_sink
      if (reset || stall_left == 0) begin
         rsp_stall <= 1'b0;
         if (!reset) begin
            if ($urandom_range(0, 39) == 0) begin
               sink_calm = !sink_calm;
            end
            stall_left = pick_gap(sink_calm);
         end
      end else begin
         rsp_stall <= 1'b1;
         stall_left--;
      end
   end

   // Monitor. Both channels are sampled at the rising edge. An accepted write updates the
   // store copy; an accepted trace is walked here and its samples queued. Each result
   // transfer is compared with the oldest expected sample.
   always @(posedge clock) begin : monitor
      addr_list_type line_addrs;
      sample_type want;
      req_taken = !reset && req_valid && !req_stall;
      if (req_taken) begin
         accepted_count++;
         if (on_bus.operation == OP_WRITE) begin
            pixel_store[on_bus.write_address] = on_bus.write_value;
            writes_done++;
         end else begin
            traces_done++;
            line_addrs = walk_line(int'(on_bus.start_x), int'(on_bus.start_y),
                                   int'(on_bus.end_x), int'(on_bus.end_y),
                                   step_setting, height_setting);
            if (line_addrs.size() == 0) begin
               empty_lines++;
            end
            foreach (line_addrs[k]) begin
               if (line_addrs[k] < STORE_DEPTH) begin
                  want.pixel_value = pixel_store[line_addrs[k][11:0]];
               end else begin
                  // A point past the end of the store reads as zero.
                  want.pixel_value = 8'h00;
                  samples_outside++;
               end
               want.last = (k == line_addrs.size() - 1);
               expected_samples.insert(expected_samples.size(), want);
            end
         end
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_samples.size() == 0) begin
            $display("%0t ns: unexpected result, expected nothing, got pixel %02h last %0b",
                     $time, rsp_pixel_value, rsp_last);
            error_count++;
         end else begin
            want = expected_samples.pop_front();
            samples_checked++;
            if (rsp_pixel_value !== want.pixel_value) begin
               $display("%0t ns: pixel_value mismatch, expected %02h, got %02h",
                        $time, want.pixel_value, rsp_pixel_value);
               error_count++;
            end
            if (rsp_last !== want.last) begin
               $display("%0t ns: last mismatch, expected %0b, got %0b",
                        $time, want.last, rsp_last);
               error_count++;
            end
         end
      end
   end

   initial begin : stimulus
      int start_mark;
      int unsigned every, rows;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part. With a step of 64 only the first point of each line is read, so
      // lines of full length cost a single pixel write each.
      apply_settings(64, 64);
      queue_write(0, 8'h00);
      queue_write(4095, 8'hFF);
      queue_trace(62, 62, 63, 63, 1'b0);   // reads the top corner of the store
      queue_trace(1, 0, 0, 0, 1'b0);       // reads address zero
      queue_trace(0, 0, 63, 63, 1'b0);     // diagonal, tie goes to the y axis
      queue_trace(63, 63, 0, 0, 1'b0);
      queue_trace(0, 63, 63, 0, 1'b1);     // anti-diagonal, offered once all is drained
      queue_trace(0, 0, 63, 1, 1'b0);      // shallow, x is the major axis
      queue_trace(5, 40, 5, 40, 1'b0);     // zero length: no sample at all
      queue_trace(33, 0, 33, 63, 1'b0);    // vertical
      wait_for_idle();

      // A step of zero emits only the first point; a height of zero folds every column
      // onto the same addresses.
      apply_settings(0, 0);
      queue_trace(3, 7, 40, 20, 1'b0);
      queue_trace(40, 20, 3, 7, 1'b0);
      wait_for_idle();

      // The largest register values: a step longer than any line, and a stride that
      // puts far points beyond the end of the store.
      apply_settings(127, 127);
      queue_trace(60, 60, 63, 63, 1'b0);
      queue_trace(0, 2, 3, 0, 1'b0);
      wait_for_idle();

      // Random phases: traces with their preparing writes, and some stray writes.
      for (int p = 0; p < 9; p++) begin
         if (p < 8) begin
            every = plan_step[p];
            rows = plan_height[p];
         end else begin
            every = $urandom_range(1, 64);
            rows = $urandom_range(1, 64);
         end
         apply_settings(every, rows);
         start_mark = queued_count;
         while (queued_count - start_mark < 37) begin
            if ($urandom_range(0, 4) == 0) begin
               queue_write($urandom_range(0, STORE_DEPTH - 1), $urandom_range(0, 255));
            end else begin
               queue_random_line($urandom_range(0, 24) == 0);
            end
         end
         wait_for_idle();
      end

      $display("Run covered %0d traces (%0d of zero length) and %0d pixel writes",
               traces_done, empty_lines, writes_done);
      $display("under %0d register settings; %0d samples compared, %0d beyond the store.",
               settings_applied, samples_checked, samples_outside);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest correct run (every result stalled at length).
   initial begin : watchdog
      #60ms;
      $display("Timeout: %0d requests accepted of %0d, %0d samples outstanding.",
               accepted_count, queued_count, expected_samples.size());
      $display("simulation failed");
      $finish;
   end

endmodule
